[src/icfu_pkg.sv]
package icfu_pkg;

    // integer and float format codes
    localparam logic [1:0] U8    = 2'd0;
    localparam logic [1:0] U16   = 2'd1;
    localparam logic [1:0] U32   = 2'd2;
    localparam logic [1:0] U64   = 2'd3;
    localparam logic [1:0] F_BAD = 2'd0;
    localparam logic [1:0] F16   = 2'd1;
    localparam logic [1:0] F32   = 2'd2;
    localparam logic [1:0] F64   = 2'd3;

    // rounding modes
    localparam logic [1:0] RND_NEAR  = 2'd0;
    localparam logic [1:0] RND_MINUS = 2'd1;
    localparam logic [1:0] RND_PLUS  = 2'd2;
    localparam logic [1:0] RND_ZERO  = 2'd3;

    // default queue depths
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_COND_CODE = 3'd1,
        ERR_HALF_SEL  = 3'd2,
        ERR_NZ_SEL    = 3'd3,
        ERR_FLOAT_FMT = 3'd4,
        ERR_UNALIGNED = 3'd5
    } t_err;

    typedef struct packed {
        logic [63:0] src_value;
        logic [1:0]  int_fmt;
        logic [1:0]  flt_fmt;
        logic        src_signed;
        logic [1:0]  byte_select;
        logic        take_abs;
        logic        negate;
        logic [1:0]  rounding;
        logic        set_cond_code;
        logic [7:0]  dest_register;
    } t_in;

    typedef struct packed {
        logic [63:0] result_bits;
        logic [1:0]  register_count;
        logic [7:0]  first_register;
        logic [2:0]  error_code;
    } t_out;

    // classified item between front and back
    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
        logic        flip;
        logic [1:0]  ffmt;
        logic [1:0]  rmode;
        logic [7:0]  dest;
        t_err        err;
    } t_work;

endpackage

[src/icfu_fifo.sv]
module icfu_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("fifo count beyond depth");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> !o_empty) else $error("fifo empty after push");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> o_full) else $error("fifo lost an entry");
endmodule

[src/icfu_front.sv]
module icfu_front (
    input  icfu_pkg::t_in   i_in,
    output icfu_pkg::t_work o_work
);
    import icfu_pkg::*;

    logic        small_fmt, is8;
    logic [15:0] fld;
    logic [31:0] ext, m, sa, least, sv, v32, src32;
    logic [4:0]  sh;
    logic [63:0] val;
    logic        at_min, neg;
    t_err        err;

    // byte or halfword extraction with small absolute value
    always_comb begin
        small_fmt = (i_in.int_fmt == U8) || (i_in.int_fmt == U16);
        is8   = (i_in.int_fmt == U8);
        fld   = 16'(i_in.src_value[31:0] >> {i_in.byte_select, 3'b000});
        if (is8) begin
            ext   = {{24{i_in.src_signed & fld[7]}}, fld[7:0]};
            sh    = 5'd7;
            least = 32'hFFFF_FF80;
        end else begin
            ext   = {{16{i_in.src_signed & fld[15]}}, fld};
            sh    = 5'd15;
            least = 32'hFFFF_8000;
        end
        m  = 32'($signed(ext) >>> sh);
        sa = (ext + m) ^ m;
        sv = (i_in.take_abs && (ext != least)) ? sa : ext;
    end

    // sign and magnitude for the converter
    always_comb begin
        src32 = i_in.src_value[31:0];
        val   = '0;
        neg   = 1'b0;
        if (small_fmt) begin
            at_min = (sv == least);
            neg    = i_in.src_signed && sv[31];
            v32    = neg ? (32'd0 - sv) : sv;
            val    = {32'd0, v32};
        end else if (i_in.int_fmt == U64) begin
            at_min = (i_in.src_value == 64'h8000_0000_0000_0000);
            v32    = '0;
            if (i_in.src_signed && i_in.src_value[63]) begin
                neg = !i_in.take_abs || at_min;
                val = 64'd0 - i_in.src_value;
            end else begin
                val = i_in.src_value;
            end
        end else begin
            at_min = (src32 == 32'h8000_0000);
            v32    = (i_in.src_signed && src32[31]) ? (32'd0 - src32) : src32;
            neg    = i_in.src_signed && src32[31] && (!i_in.take_abs || at_min);
            val    = {32'd0, v32};
        end
    end

    // error precedence
    always_comb begin
        if (i_in.set_cond_code) begin
            err = ERR_COND_CODE;
        end else if (i_in.int_fmt == U16 && i_in.byte_select[0]) begin
            err = ERR_HALF_SEL;
        end else if (!small_fmt && i_in.byte_select != 2'd0) begin
            err = ERR_NZ_SEL;
        end else if (i_in.flt_fmt == F_BAD) begin
            err = ERR_FLOAT_FMT;
        end else if (i_in.flt_fmt == F64 && i_in.dest_register[0]) begin
            err = ERR_UNALIGNED;
        end else begin
            err = ERR_NONE;
        end
    end

    assign o_work.mag   = val;
    assign o_work.neg   = neg;
    assign o_work.flip  = i_in.negate &&
                          (i_in.take_abs || !i_in.src_signed || !at_min);
    assign o_work.ffmt  = i_in.flt_fmt;
    assign o_work.rmode = i_in.rounding;
    assign o_work.dest  = i_in.dest_register;
    assign o_work.err   = err;
endmodule

[src/icfu_back.sv]
module icfu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  icfu_pkg::t_work i_work,
    input  logic            i_valid,
    output logic            o_take,
    output icfu_pkg::t_out  o_res,
    output logic            o_res_valid,
    input  logic            i_res_full
);
    import icfu_pkg::*;

    logic        r_v1;
    t_work       r_w1;
    logic [5:0]  r_lz;
    logic        adv;
    logic [5:0]  lz;

    logic [63:0] norm;
    logic [52:0] kept;
    logic [53:0] kinc;
    logic        g, s, up, carry, ovf, to_inf, lsb;
    logic [6:0]  e, e2;
    logic [51:0] man;
    logic [63:0] res;

    assign adv         = !(r_v1 && i_res_full);
    assign o_take      = i_valid && adv;
    assign o_res_valid = r_v1;

    // leading zero count
    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (i_work.mag[i]) begin
                lz = 6'(63 - i);
            end
        end
    end

    // stage one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_w1 <= i_work;
            r_lz <= lz;
        end
    end

    // normalize, round and pack
    always_comb begin
        norm = r_w1.mag << r_lz;
        e    = 7'd63 - {1'b0, r_lz};
        unique case (r_w1.ffmt)
            F16: begin
                kept = {42'd0, norm[63:53]};
                g    = norm[52];
                s    = |norm[51:0];
                lsb  = norm[53];
            end
            F32: begin
                kept = {29'd0, norm[63:40]};
                g    = norm[39];
                s    = |norm[38:0];
                lsb  = norm[40];
            end
            default: begin
                kept = norm[63:11];
                g    = norm[10];
                s    = |norm[9:0];
                lsb  = norm[11];
            end
        endcase
        unique case (r_w1.rmode)
            RND_NEAR:  up = g && (s || lsb);
            RND_MINUS: up = r_w1.neg && (g || s);
            RND_PLUS:  up = !r_w1.neg && (g || s);
            default:   up = 1'b0;
        endcase
        unique case (r_w1.rmode)
            RND_NEAR:  to_inf = 1'b1;
            RND_MINUS: to_inf = r_w1.neg;
            RND_PLUS:  to_inf = !r_w1.neg;
            default:   to_inf = 1'b0;
        endcase
        kinc = {1'b0, kept} + 54'(up);
        unique case (r_w1.ffmt)
            F16:     carry = kinc[11];
            F32:     carry = kinc[24];
            default: carry = kinc[53];
        endcase
        e2  = e + 7'(carry);
        man = carry ? '0 : kinc[51:0];
        ovf = (e2 > 7'd15);
        unique case (r_w1.ffmt)
            F16: begin
                if (ovf) begin
                    res = {48'd0, r_w1.neg, to_inf ? 15'h7C00 : 15'h7BFF};
                end else begin
                    res = {48'd0, r_w1.neg, 5'(e2 + 7'd15), man[9:0]};
                end
            end
            F32: res = {32'd0, r_w1.neg, 8'(e2) + 8'd127, man[22:0]};
            default: res = {r_w1.neg, 11'(e2) + 11'd1023, man};
        endcase
        if (r_w1.mag == '0) begin
            res = '0;
        end
        if (r_w1.flip) begin
            unique case (r_w1.ffmt)
                F16:     res[15] = ~res[15];
                F32:     res[31] = ~res[31];
                default: res[63] = ~res[63];
            endcase
        end
    end

    // result record, zero on error
    always_comb begin
        if (r_w1.err != ERR_NONE) begin
            o_res.result_bits    = '0;
            o_res.register_count = 2'd0;
            o_res.first_register = '0;
        end else begin
            o_res.result_bits    = res;
            o_res.register_count = (r_w1.ffmt == F64) ? 2'd2 : 2'd1;
            o_res.first_register = r_w1.dest;
        end
        o_res.error_code = r_w1.err;
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && i_res_full) |=> r_v1) else $error("stage one dropped on stall");
    a_take_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_v1) else $error("taken item not in stage one");
    a_half_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_w1.ffmt == F16) |-> o_res.result_bits[63:16] == '0)
        else $error("half result with upper bits set");
endmodule

[src/int_to_float_convert_unit.sv]
// an input passes the mid queue, back stage register and result queue
// throughput: one item per cycle unless the result queue is full, set
// by the single-stage back pipeline draining one queue entry per cycle
// reset: synchronous active-low i_rst_n empties both queues and the stage
// register; no clearing pass is needed
module int_to_float_convert_unit #(
    parameter int MID_DEPTH = icfu_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = icfu_pkg::OUT_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  icfu_pkg::t_in  i_in,
    output logic           full,
    input  logic           pop,
    output icfu_pkg::t_out o_out,
    output logic           empty
);
    import icfu_pkg::*;

    t_work w_front, w_mid;
    logic  mid_empty, take;
    t_out  res;
    logic  res_valid, res_full;

    // classify the incoming item
    icfu_front u_front (
        .i_in   (i_in),
        .o_work (w_front)
    );

    // queue between front and back
    icfu_fifo #(.T(t_work), .DEPTH(MID_DEPTH)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_front),
        .o_full  (full),
        .i_pop   (take),
        .o_data  (w_mid),
        .o_empty (mid_empty)
    );

    // conversion pipeline
    icfu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work      (w_mid),
        .i_valid     (!mid_empty),
        .o_take      (take),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_full  (res_full)
    );

    // result queue
    icfu_fifo #(.T(t_out), .DEPTH(OUT_DEPTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty) else $error("result after reset");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.error_code != ERR_NONE) |->
        (o_out.register_count == 2'd0 && o_out.result_bits == '0))
        else $error("error result not cleared");
    a_double_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.register_count == 2'd2) |-> !o_out.first_register[0])
        else $error("double to odd register");
endmodule
